// File: rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character decode function used by the
// base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3d;   // '='
    localparam logic [7:0] NUL_CHAR   = 8'h00;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] HT_CHAR    = 8'h09;
    localparam logic [7:0] CR_CHAR    = 8'h0d;

    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // One unit of work for the output side: up to three results.
    typedef struct packed {
        logic [23:0] word;        // decoded bytes, first byte in [23:16]
        logic [1:0]  count;       // number of results, 1..3
        logic        byte_valid;  // results carry bytes
        logic        done;        // last result closes the message
        logic        err;         // message status on the last result
    } job_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t    s;
        logic [7:0] t;
        s = '{ok: 1'b0, value: 6'd0};
        t = 8'd0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            t = c - 8'h41;
            s = '{ok: 1'b1, value: t[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            t = c - 8'h61 + 8'd26;
            s = '{ok: 1'b1, value: t[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30 + 8'd52;
            s = '{ok: 1'b1, value: t[5:0]};
        end else if (c == 8'h2b) begin
            s = '{ok: 1'b1, value: 6'd62};
        end else if (c == 8'h2f) begin
            s = '{ok: 1'b1, value: 6'd63};
        end
        return s;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == SPACE_CHAR) || (c >= HT_CHAR && c <= CR_CHAR);
    endfunction

endpackage

// File: rtl/core/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, skips whitespace, collects groups of four and turns
// each completed group or message end into a job for the output side.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_text_char,
    input  logic             s_end_of_text,
    input  logic             q_full,
    output logic             q_push,
    output b64d_pkg::job_t   q_job
);

    logic [7:0]        chars_reg [4];
    logic [2:0]        fill_reg;
    logic [2:0]        fill_next;
    logic              err_reg;
    logic              err_next;

    logic              accept;
    logic              is_end;
    logic              is_skip;
    logic              group_full;
    b64d_pkg::sextet_t sx [4];
    logic [1:0]        pads;
    logic [3:0]        used;
    logic [23:0]       word_mid;
    logic [23:0]       word_fin;
    logic              bad_mid;
    logic              bad_fin;
    logic              err_fin;
    b64d_pkg::job_t    job;

    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign is_end     = s_end_of_text || (s_text_char == b64d_pkg::NUL_CHAR);
    assign is_skip    = !is_end && b64d_pkg::is_blank(s_text_char);
    assign group_full = (fill_reg == 3'd4);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sx[i] = b64d_pkg::sextet_of(chars_reg[i]);
        end
        // Only one or two trailing pads count as padding.
        if (chars_reg[3] == b64d_pkg::PAD_CHAR) begin
            pads = (chars_reg[2] == b64d_pkg::PAD_CHAR) ? 2'd2 : 2'd1;
        end else begin
            pads = 2'd0;
        end
        used     = {pads == 2'd0, pads != 2'd2, 1'b1, 1'b1};
        word_mid = {sx[0].value, sx[1].value, sx[2].value, sx[3].value};
        bad_mid  = !(sx[0].ok && sx[1].ok && sx[2].ok && sx[3].ok);
        word_fin = {sx[0].value, sx[1].value,
                    used[2] ? sx[2].value : 6'd0,
                    used[3] ? sx[3].value : 6'd0};
        bad_fin  = !sx[0].ok || !sx[1].ok || (used[2] && !sx[2].ok)
                 || (used[3] && !sx[3].ok);
        err_fin  = err_reg || (fill_reg != 3'd0 && !group_full)
                 || (group_full && bad_fin);
    end

    always_comb begin
        job       = '{word: 24'd0, count: 2'd1, byte_valid: 1'b0,
                      done: 1'b1, err: 1'b0};
        q_push    = 1'b0;
        fill_next = fill_reg;
        err_next  = err_reg;
        if (accept) begin
            priority if (is_end) begin
                q_push    = 1'b1;
                fill_next = 3'd0;
                err_next  = 1'b0;
                if (err_fin) begin
                    job.err = 1'b1;
                end else if (group_full) begin
                    job.word       = word_fin;
                    job.count      = 2'd3 - pads;
                    job.byte_valid = 1'b1;
                end
            end else if (is_skip) begin
                // drop whitespace
            end else if (!group_full) begin
                fill_next = fill_reg + 3'd1;
            end else begin
                // more text follows: the held group is a middle group
                q_push    = 1'b1;
                job       = '{word: word_mid, count: 2'd3, byte_valid: 1'b1,
                              done: 1'b0, err: 1'b0};
                err_next  = err_reg || bad_mid;
                fill_next = 3'd1;
            end
        end
    end

    assign q_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 3'd0;
            err_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !is_end && !is_skip) begin
            if (group_full) begin
                chars_reg[0] <= s_text_char;
            end else begin
                chars_reg[fill_reg[1:0]] <= s_text_char;
            end
        end
    end

endmodule

// File: rtl/core/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between the character side and the byte side.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  b64d_pkg::job_t   push_job,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output b64d_pkg::job_t   head_job
);

    localparam int unsigned PW = b64d_pkg::Q_PTR_W;
    localparam int unsigned CW = b64d_pkg::Q_CNT_W;

    b64d_pkg::job_t  mem_reg [b64d_pkg::Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full       = (count_reg == CW'(b64d_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(b64d_pkg::Q_DEPTH - 1))
                            ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(b64d_pkg::Q_DEPTH - 1))
                            ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count did not advance on push");

endmodule

// File: rtl/core/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Takes queue jobs; emits one result per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  b64d_pkg::job_t   q_job,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_message_done,
    output logic             m_decode_error
);

    logic        busy_reg;
    logic [23:0] word_reg;
    logic [1:0]  left_reg;
    logic        bv_reg;
    logic        done_reg;
    logic        err_reg;
    logic        last;

    assign last  = (left_reg == 2'd1);
    assign q_pop = q_valid && (!busy_reg || (m_ready && last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
        end else if (m_ready && last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            word_reg <= q_job.word;
            left_reg <= q_job.count;
            bv_reg   <= q_job.byte_valid;
            done_reg <= q_job.done;
            err_reg  <= q_job.err;
        end else if (busy_reg && m_ready && !last) begin
            // advance to the next byte of the group
            word_reg <= {word_reg[15:0], 8'd0};
            left_reg <= left_reg - 2'd1;
        end
    end

    assign m_valid        = busy_reg;
    assign m_out_byte     = word_reg[23:16];
    assign m_byte_valid   = bv_reg;
    assign m_message_done = done_reg && last;
    assign m_decode_error = err_reg && last;

    a_err_status_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_decode_error) |-> (m_message_done && !m_byte_valid))
        else $error("error flagged on a byte result");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_byte)
                                  && $stable(m_message_done)))
        else $error("stalled result changed");

    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (left_reg != 2'd0))
        else $error("active job with no results left");

endmodule

// File: rtl/core/base64_stream_decoder.sv
// Path: the item that completes a job (the character after a full group, or
//   the end of message) writes it into the queue, and the back end loads it
//   into its output registers. Throughput: one character per cycle while
//   the queue is not full; one result per cycle while m_ready is high.
// Reset: aresetn is synchronous, active low; clears fill, error and queue.
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: character front end, job queue, byte back end.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_char,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_message_done,
    output logic        m_decode_error
);

    logic            q_full;
    logic            q_push;
    b64d_pkg::job_t  q_push_job;
    logic            q_pop;
    logic            q_head_valid;
    b64d_pkg::job_t  q_head_job;

    b64d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_char   (s_text_char),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_push_job)
    );

    b64d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    b64d_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_head_valid),
        .q_job          (q_head_job),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_message_done (m_message_done),
        .m_decode_error (m_decode_error)
    );

endmodule

// File: verif/base64_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_test
// Self-checking bench for the base64 stream decoder. A queue of character
// items, directed cases first and then random messages, feeds a driver. A
// scoreboard decodes every accepted item and checks each result item, field by
// field, against the oldest decoded byte waiting. Sender and receiver idle at
// random in the first two of three phases, and the receiver once holds off
// long enough to back up the input.
// ----------------------------------------------------------------------------
module base64_stream_decoder_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 450;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done;
        logic       err;
    } decoded_t;

    logic       aclk;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_char    = 8'h00;
    logic       s_end_of_text  = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_message_done;
    logic       m_decode_error;

    text_item_t pending_chars[$];
    decoded_t   decoded_results[$];

    // decoder state mirrored by the scoreboard
    logic [7:0] held_chars[4];
    int         held_count  = 0;
    logic       msg_error   = 1'b0;

    int   total_items  = 1;
    int   chars_taken  = 0;
    int   fail_count   = 0;
    int   cycle_count  = 0;
    logic in_fire      = 1'b0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;

    base64_stream_decoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_char    (s_text_char),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_message_done (m_message_done),
        .m_decode_error (m_decode_error)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------- predictor

    // {in alphabet, sextet value}
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5a) begin          // A..Z
            t = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7a) begin // a..z
            t = c - 8'h47;
        end else if (c >= 8'h30 && c <= 8'h39) begin // 0..9
            t = c + 8'h04;
        end else if (c == 8'h2b) begin               // +
            t = 8'd62;
        end else if (c == 8'h2f) begin               // /
            t = 8'd63;
        end else begin
            return 7'h00;
        end
        return {1'b1, t[5:0]};
    endfunction

    // Pack the first count held characters, the rest as zero; flag any bad one.
    function automatic logic pack_group(input int count, output logic [23:0] word);
        logic       bad;
        logic [6:0] sx;
        bad  = 1'b0;
        word = 24'h0;
        for (int i = 0; i < 4; i++) begin
            sx = 7'h00;
            if (i < count) begin
                sx = char_sextet(held_chars[i]);
                if (!sx[6])
                    bad = 1'b1;
            end
            word = {word[17:0], sx[5:0]};
        end
        return bad;
    endfunction

    task automatic push_decoded(input logic [7:0] b, input logic bv, input logic d,
                                input logic e);
        decoded_t r;
        r.out_byte   = b;
        r.byte_valid = bv;
        r.done       = d;
        r.err        = e;
        decoded_results.push_back(r);
    endtask

    task automatic close_message();
        logic        err;
        int          n;
        int          pads;
        logic [23:0] word;
        err  = msg_error;
        n    = 0;
        word = 24'h0;
        if (held_count > 0 && held_count < 4) begin
            err = 1'b1;
        end else if (held_count == 4) begin
            pads = 0;
            while (pads < 2 && held_chars[3 - pads] == b64d_pkg::PAD_CHAR)
                pads++;
            if (pack_group(4 - pads, word))
                err = 1'b1;
            n = 3 - pads;
        end
        held_count = 0;
        msg_error  = 1'b0;
        if (err) begin
            push_decoded(8'h00, 1'b0, 1'b1, 1'b1);
        end else if (n == 0) begin
            push_decoded(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
            for (int k = 0; k < n; k++)
                push_decoded(word[23 - 8 * k -: 8], 1'b1, k == n - 1, 1'b0);
        end
    endtask

    task automatic decode_char(input logic [7:0] c, input logic eot);
        logic [23:0] word;
        if (eot || c == b64d_pkg::NUL_CHAR) begin
            close_message();
        end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
            // skip whitespace
        end else if (held_count < 4) begin
            held_chars[held_count] = c;
            held_count++;
        end else begin
            if (pack_group(4, word))
                msg_error = 1'b1;
            for (int k = 0; k < 3; k++)
                push_decoded(word[23 - 8 * k -: 8], 1'b1, 1'b0, 1'b0);
            held_chars[0] = c;
            held_count    = 1;
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] alpha_char(input int v);
        if (v < 26)
            return 8'(65 + v);
        if (v < 52)
            return 8'(97 + (v - 26));
        if (v < 62)
            return 8'(48 + (v - 52));
        return (v == 62) ? 8'h2b : 8'h2f;
    endfunction

    function automatic logic [7:0] blank_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(9 + k);
    endfunction

    task automatic push_char(input logic [7:0] c);
        text_item_t it;
        it.ch  = c;
        it.eot = 1'b0;
        pending_chars.push_back(it);
    endtask

    task automatic push_end(input logic [7:0] c);
        text_item_t it;
        it.ch  = c;
        it.eot = 1'b1;
        pending_chars.push_back(it);
    endtask

    task automatic push_str(input string s);
        foreach (s[i])
            push_char(s[i]);
    endtask

    task automatic add_random_message();
        logic [7:0] body[$];
        int         kind;
        int         groups;
        int         pads;
        int         pos;
        kind = $urandom_range(0, 99);
        if (kind < 82) begin
            groups = $urandom_range(0, 4);
            repeat (groups * 4)
                body.push_back(alpha_char($urandom_range(0, 63)));
            if (groups > 0) begin
                pads = $urandom_range(0, 2);
                for (int j = 0; j < pads; j++)
                    body[body.size() - 1 - j] = b64d_pkg::PAD_CHAR;
            end
            // break some of the well-formed messages
            if (kind >= 66 && body.size() > 0) begin
                pos = $urandom_range(0, body.size() - 1);
                case ($urandom_range(0, 2))
                    0: begin
                        body[pos] = 8'($urandom_range(1, 255));
                    end
                    1: begin
                        body.delete(pos);
                    end
                    default: begin
                        body.insert(pos, alpha_char($urandom_range(0, 63)));
                    end
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 9))
                body.push_back(8'($urandom_range(0, 255)));
        end
        foreach (body[i]) begin
            if ($urandom_range(0, 9) == 0)
                push_char(blank_char());
            push_char(body[i]);
        end
        if ($urandom_range(0, 3) == 0)
            push_char(b64d_pkg::NUL_CHAR);
        else
            push_end(8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------- idling

    function automatic int idle_phase();
        int p;
        p = chars_taken * 3 / total_items;
        return (p > 2) ? 2 : p;
    endfunction

    function automatic int tx_idle_pct();
        case (idle_phase())
            0:       return 21;
            1:       return 84;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct();
        case (idle_phase())
            0:       return 84;
            1:       return 21;
            default: return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver

    always @(negedge aclk) begin
        if (aresetn) begin
            // hold the item until it is taken
            if (!s_valid || in_fire) begin
                if (pending_chars.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
                    s_valid       <= 1'b1;
                    s_text_char   <= pending_chars[0].ch;
                    s_end_of_text <= pending_chars[0].eot;
                    pending_chars.pop_front();
                end else begin
                    s_valid       <= 1'b0;
                    s_text_char   <= 8'($urandom_range(0, 255));
                    s_end_of_text <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && idle_phase() == 2) begin
                // stall the output long enough to back up the input
                m_ready   <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct());
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        decoded_t r;
        if (aresetn) begin
            in_fire <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (decoded_results.size() == 0) begin
                    $error("result item with nothing expected: out_byte %0h", m_out_byte);
                    fail_count++;
                end else begin
                    r = decoded_results.pop_front();
                    check_field("out_byte", r.out_byte, m_out_byte);
                    check_field("byte_valid", r.byte_valid, m_byte_valid);
                    check_field("message_done", r.done, m_message_done);
                    check_field("decode_error", r.err, m_decode_error);
                end
            end
            if (s_valid && s_ready) begin
                chars_taken++;
                decode_char(s_text_char, s_end_of_text);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        // whitespace inside a full final group, end marker with 0xff ignored
        push_str("TW");
        push_char(8'h0a);
        push_str("Fu");
        push_end(8'hff);
        // two pads, NUL ends the message
        push_str("TQ==");
        push_char(b64d_pkg::NUL_CHAR);
        // empty message
        push_end(8'hff);
        // pad and a high byte in a middle group, misplaced pads at the end
        push_char(b64d_pkg::PAD_CHAR);
        push_char(8'h80);
        push_str("+/x===");
        push_end(8'h41);
        // partial final group
        push_str("z");
        push_end(8'h00);

        while (pending_chars.size() < RANDOM_ITEMS)
            add_random_message();
        total_items = pending_chars.size();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() != 0 || s_valid || decoded_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && decoded_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
